// ===== hdl/mfbp_pkg.sv =====
// Package for the MSB-first field bit packer.
// Holds the field widths, the capacity reset value and the input transaction type.
// No dependencies.
package mfbp_pkg;

   localparam int VALUE_W         = 16;
   localparam int WIDTH_W         = 5;
   localparam int BYTE_W          = 8;
   localparam int PEND_W          = 7;
   localparam int PCNT_W          = 3;
   localparam int ACC_W           = PEND_W + VALUE_W;
   localparam int BUF_W           = 24;
   localparam int CNT_W           = 5;
   localparam int NLEFT_W         = 2;
   localparam int MAX_FIELD_WIDTH = 16;

   localparam logic [WIDTH_W-1:0] FIELD_LIMIT =
      (MAX_FIELD_WIDTH < VALUE_W) ? WIDTH_W'(MAX_FIELD_WIDTH) : WIDTH_W'(VALUE_W);

   localparam logic [BYTE_W-1:0] MAX_BYTES_RESET = 8'd220;
   localparam logic [BYTE_W-1:0] INDEX_SAT       = 8'd255;

   typedef struct packed {
      logic [VALUE_W-1:0] field_value;
      logic [WIDTH_W-1:0] field_width;
      logic               end_of_record;
   } item_type;

endpackage

// ===== hdl/mfbp_in_reg.sv =====
// Input register of the bit packer.
// Captures one request transaction and holds it until the packing core takes it.
// Depends on mfbp_pkg.
module mfbp_in_reg
   import mfbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_field_value,
   input  logic [WIDTH_W-1:0] req_field_width,
   input  logic               req_end_of_record,
   output logic               item_valid,
   output item_type           item,
   input  logic               item_take
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_stall  = valid_ff && !item_take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.field_value   <= req_field_value;
         item_ff.field_width   <= req_field_width;
         item_ff.end_of_record <= req_end_of_record;
      end
   end

endmodule

// ===== hdl/mfbp_core.sv =====
// Packing core: aligns a field behind the pending bits, then issues one byte a cycle while not stalled.
// Keeps the pending bits, the record byte count and the result register.
// Depends on mfbp_pkg.
module mfbp_core
   import mfbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  item_type          item,
   output logic              item_take,
   input  logic [BYTE_W-1:0] max_bytes,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic [BYTE_W-1:0] rsp_byte_index,
   output logic              rsp_record_done,
   output logic [BYTE_W-1:0] rsp_record_length,
   output logic              rsp_overflow
);

   logic [PEND_W-1:0]  pend_ff, pend_in;
   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [BYTE_W-1:0]  bytes_ff, bytes_in;
   logic [BUF_W-1:0]   buf_ff, buf_in;
   logic [NLEFT_W-1:0] nleft_ff, nleft_in;
   logic               eor_ff, eor_in;
   logic               bare_ff, bare_in;

   logic               rvalid_ff, rvalid_in;
   logic [BYTE_W-1:0]  rbyte_ff;
   logic               rbvalid_ff;
   logic [BYTE_W-1:0]  rindex_ff;
   logic               rdone_ff;
   logic [BYTE_W-1:0]  rlen_ff;
   logic               rovf_ff;

   logic [WIDTH_W-1:0] w_cl;
   logic [VALUE_W:0]   mask;
   logic [VALUE_W-1:0] val_m;
   logic [ACC_W-1:0]   acc;
   logic [CNT_W-1:0]   cnt0;
   logic [CNT_W-1:0]   sh;
   logic [BUF_W-1:0]   aligned;
   logic [PCNT_W-1:0]  rem;
   logic [NLEFT_W-1:0] nfull;
   logic [BYTE_W-1:0]  rem_mask;
   logic [NLEFT_W-1:0] n_new;
   logic               bare_new;

   logic               out_free;
   logic               issue;
   logic               last;
   logic [BYTE_W-1:0]  bytes_inc;
   logic               o_done;
   logic [BYTE_W-1:0]  o_len;
   logic               o_ovf;

   // align the new field behind the pending bits, earliest bit at the top
   always_comb begin
      w_cl     = (item.field_width > FIELD_LIMIT) ? FIELD_LIMIT : item.field_width;
      mask     = ((VALUE_W+1)'(1) << w_cl) - (VALUE_W+1)'(1);
      val_m    = item.field_value & mask[VALUE_W-1:0];
      acc      = (ACC_W'(pend_ff) << w_cl) | ACC_W'(val_m);
      cnt0     = CNT_W'(pcnt_ff) + w_cl;
      sh       = CNT_W'(BUF_W) - cnt0;
      aligned  = BUF_W'(acc) << sh;
      nfull    = cnt0[CNT_W-1:PCNT_W];
      rem      = cnt0[PCNT_W-1:0];
      rem_mask = (BYTE_W'(1) << rem) - BYTE_W'(1);
      n_new    = nfull;
      bare_new = 1'b0;
      if (item.end_of_record) begin
         if (rem != '0) begin
            n_new = nfull + NLEFT_W'(1);
         end else if (nfull == '0) begin
            n_new    = NLEFT_W'(1);
            bare_new = 1'b1;
         end
      end
   end

   assign out_free  = !rvalid_ff || !rsp_stall;
   assign issue     = (nleft_ff != '0) && out_free;
   assign last      = (nleft_ff == NLEFT_W'(1));
   assign item_take = item_valid && ((nleft_ff == '0) || (last && issue));
   assign bytes_inc = (bytes_ff == INDEX_SAT) ? bytes_ff : bytes_ff + BYTE_W'(1);

   always_comb begin
      o_done = eor_ff && last;
      o_len  = '0;
      o_ovf  = bytes_ff >= max_bytes;
      if (bare_ff) begin
         o_ovf = bytes_ff > max_bytes;
      end
      if (o_done) begin
         o_len = bare_ff ? bytes_ff : bytes_inc;
      end
   end

   always_comb begin
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      bytes_in  = bytes_ff;
      buf_in    = buf_ff;
      nleft_in  = nleft_ff;
      eor_in    = eor_ff;
      bare_in   = bare_ff;
      rvalid_in = rvalid_ff;
      if (issue) begin
         buf_in    = buf_ff << BYTE_W;
         nleft_in  = nleft_ff - NLEFT_W'(1);
         rvalid_in = 1'b1;
         if (o_done) begin
            bytes_in = '0;
         end else if (!bare_ff) begin
            bytes_in = bytes_inc;
         end
      end else if (!rsp_stall) begin
         rvalid_in = 1'b0;
      end
      if (item_take) begin
         buf_in   = aligned;
         nleft_in = n_new;
         eor_in   = item.end_of_record;
         bare_in  = bare_new;
         if (item.end_of_record) begin
            pend_in = '0;
            pcnt_in = '0;
         end else begin
            pend_in = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
            pcnt_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         pcnt_ff   <= '0;
         bytes_ff  <= '0;
         nleft_ff  <= '0;
         eor_ff    <= 1'b0;
         bare_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         pcnt_ff   <= pcnt_in;
         bytes_ff  <= bytes_in;
         nleft_ff  <= nleft_in;
         eor_ff    <= eor_in;
         bare_ff   <= bare_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (issue) begin
         rbyte_ff   <= buf_ff[BUF_W-1 -: BYTE_W];
         rbvalid_ff <= !bare_ff;
         rindex_ff  <= bytes_ff;
         rdone_ff   <= o_done;
         rlen_ff    <= o_len;
         rovf_ff    <= o_ovf;
      end
   end

   assign rsp_valid         = rvalid_ff;
   assign rsp_out_byte      = rbyte_ff;
   assign rsp_byte_valid    = rbvalid_ff;
   assign rsp_byte_index    = rindex_ff;
   assign rsp_record_done   = rdone_ff;
   assign rsp_record_length = rlen_ff;
   assign rsp_overflow      = rovf_ff;

endmodule

// ===== hdl/msb_first_field_bit_packer.sv =====
// MSB-first field bit packer, top level.
// A request passes through the input register, the core's byte buffer and the result
// register. Throughput: one result per cycle while not stalled, from the single result
// register; the next transaction is taken as the last result of the one before issues.
// Reset (synchronous, active high) empties both registers, clears the record state
// and sets the capacity to 220. Depends on mfbp_pkg, mfbp_in_reg and mfbp_core.
module msb_first_field_bit_packer
   import mfbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [BYTE_W-1:0]  csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_field_value,
   input  logic [WIDTH_W-1:0] req_field_width,
   input  logic               req_end_of_record,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic [BYTE_W-1:0]  rsp_byte_index,
   output logic               rsp_record_done,
   output logic [BYTE_W-1:0]  rsp_record_length,
   output logic               rsp_overflow
);

   logic [BYTE_W-1:0] max_bytes_ff;
   logic              item_valid;
   item_type          item;
   logic              item_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end

   mfbp_in_reg u_in_reg (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_field_value   (req_field_value),
      .req_field_width   (req_field_width),
      .req_end_of_record (req_end_of_record),
      .item_valid        (item_valid),
      .item              (item),
      .item_take         (item_take)
   );

   mfbp_core u_core (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_take         (item_take),
      .max_bytes         (max_bytes_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_record_done   (rsp_record_done),
      .rsp_record_length (rsp_record_length),
      .rsp_overflow      (rsp_overflow)
   );

endmodule
